@@ rtl/core/tpc_pkg.sv @@
package tpc_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam logic [16:0] HDR_LEN = 17'd12;
    localparam logic [16:0] POS_MAX = 17'd131071;

    localparam logic [31:0] SEED_A = 32'hdeadbeef;
    localparam logic [31:0] SEED_B = 32'h0badcafe;
    localparam logic [31:0] SEED_C = 32'hdeadface;
    localparam logic [31:0] SEED_D = 32'hdefaced1;
    localparam logic [31:0] MIX_B  = 32'h89abcdef;
    localparam logic [31:0] MIX_C  = 32'h31415926;
    localparam logic [31:0] MIX_A  = 32'h01234567;
    localparam logic [31:0] MIX_D  = 32'h54581414;

    localparam logic [1:0] OUTCOME_OK    = 2'd0;
    localparam logic [1:0] OUTCOME_SHORT = 2'd1;
    localparam logic [1:0] OUTCOME_BAD   = 2'd2;

    typedef struct packed {
        logic take;
        logic gen;
        logic fin;
        logic scan1;
        logic scan2;
        logic restart;
        logic swap_head;
        logic swap_js;
        logic insert;
    } cmd_t;

    typedef struct packed {
        logic payload;
        logic short_pkt;
        logic hdr_bad;
        logic empty;
        logic full;
        logic scan_done;
        logic dup;
    } status_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] y);
        logic [63:0] t;
        t = {x, x} << y;
        return t[63:32];
    endfunction

endpackage

@@ rtl/core/tpc_ram.sv @@
module tpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/tpc_ctrl.sv @@
module tpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  logic              last_byte,
    output logic              result_valid,
    input  logic              result_ready,
    input  tpc_pkg::status_t  st,
    output tpc_pkg::cmd_t     cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GEN   = 4'd1;
    localparam logic [3:0] S_FIN   = 4'd2;
    localparam logic [3:0] S_SCAN1 = 4'd3;
    localparam logic [3:0] S_SCAN2 = 4'd4;
    localparam logic [3:0] S_SWAPH = 4'd5;
    localparam logic [3:0] S_SWAPJ = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign data_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (data_valid)
                begin
                    cmd.take  = 1'b1;
                    last_next = last_byte;
                    if (st.payload)
                    begin
                        state_next = S_GEN;
                    end
                    else if (last_byte)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_GEN:
            begin
                cmd.gen    = 1'b1;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (st.short_pkt || st.hdr_bad)
                begin
                    state_next = S_OUT;
                end
                else if (st.empty)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                cmd.scan1 = 1'b1;
                if (st.scan_done)
                begin
                    if (st.dup)
                    begin
                        state_next = S_OUT;
                    end
                    else if (st.full)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_SCAN2;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
            end
            S_SCAN2:
            begin
                cmd.scan2 = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_SWAPH;
                end
            end
            S_SWAPH:
            begin
                cmd.swap_head = 1'b1;
                state_next    = S_SWAPJ;
            end
            S_SWAPJ:
            begin
                cmd.swap_js = 1'b1;
                state_next  = S_INS;
            end
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/tpc_datapath.sv @@
module tpc_datapath #(
    parameter int WINDOW_DEPTH = tpc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  tpc_pkg::cmd_t     cmd,
    output tpc_pkg::status_t  st,
    output logic [1:0]        outcome,
    output logic              misordered,
    output logic              duplicate,
    output logic              truncated,
    output logic              payload_bad,
    output logic [31:0]       sequence_res,
    output logic [15:0]       byte_errors,
    output logic              gap_found,
    output logic [31:0]       gap_first,
    output logic [31:0]       gap_last
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = FW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(WINDOW_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);

    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] a, input logic [FW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IW-1:0];
    endfunction

    logic [16:0] pos_reg;
    logic [31:0] seq_reg, ts_reg;
    logic [15:0] size_reg, chk_reg;
    logic [31:0] g0_reg, g1_reg, g2_reg, g3_reg;
    logic [7:0]  byte_reg;
    logic [15:0] mcnt_reg;
    logic        bad_reg;
    logic [31:0] prev_reg;
    logic        seen_reg;
    logic [IW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] cnt_reg;
    logic          pend_reg;
    logic [IW-1:0] off_reg, phys_reg;
    logic [31:0]   s0_reg, s1_reg, h0_reg;
    logic [IW-1:0] js_reg;
    logic          have_reg, dup_reg;

    logic [1:0]  r_outcome_reg;
    logic        r_ooo_reg, r_trunc_reg, r_pbad_reg, r_gap_reg;
    logic [31:0] r_seq_reg, r_first_reg, r_last_reg;
    logic [15:0] r_err_reg;

    logic [31:0] a1, b1, c1, d1, a3, b2, b3, c3, d3, seed;
    logic [15:0] chk_new, sum16;
    logic [31:0] v;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    logic [16:0]   plen;

    tpc_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (v)
    );

    assign rd_addr = wrap(head_reg, cnt_reg);

    always_comb
    begin
        wr_en   = cmd.swap_head | cmd.swap_js | cmd.insert;
        wr_addr = head_reg;
        wr_data = s0_reg;
        if (cmd.swap_js)
        begin
            wr_addr = js_reg;
            wr_data = h0_reg;
        end
        else if (cmd.insert)
        begin
            wr_addr = wrap(head_reg, fill_reg);
            wr_data = seq_reg;
        end
    end

    // generator, first half from stored words, second half from the half-updated words
    assign a1 = tpc_pkg::rotl(g0_reg, g3_reg[4:0]);
    assign b1 = g1_reg ^ tpc_pkg::MIX_B;
    assign c1 = tpc_pkg::rotl(g2_reg, b1[4:0]) ^ tpc_pkg::MIX_C;
    assign d1 = tpc_pkg::rotl(g3_reg, g0_reg[4:0]);
    assign b2 = tpc_pkg::rotl(g1_reg, g2_reg[4:0]);
    assign a3 = (g0_reg ^ tpc_pkg::MIX_A) + g2_reg;
    assign b3 = b2 ^ d1;
    assign c3 = g2_reg - a3;
    assign d3 = (d1 - b3) ^ tpc_pkg::MIX_D;

    assign chk_new = {chk_reg[7:0], data_byte};
    assign seed    = {16'd0, chk_new};
    assign sum16   = ~(seq_reg[15:0] ^ ts_reg[15:0] ^ size_reg);
    assign plen    = pos_reg - tpc_pkg::HDR_LEN;

    always_comb
    begin
        st.payload   = (pos_reg >= tpc_pkg::HDR_LEN);
        st.short_pkt = (pos_reg < tpc_pkg::HDR_LEN);
        st.hdr_bad   = bad_reg;
        st.empty     = (fill_reg == '0);
        st.full      = (fill_reg == DEPTH_F);
        st.scan_done = (cnt_reg == fill_reg) && !pend_reg;
        st.dup       = dup_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            mcnt_reg <= '0;
            bad_reg  <= 1'b0;
            prev_reg <= '0;
            seen_reg <= 1'b0;
            head_reg <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            seq_reg  <= '0;
            ts_reg   <= '0;
            size_reg <= '0;
            chk_reg  <= '0;
            g0_reg   <= '0;
            g1_reg   <= '0;
            g2_reg   <= '0;
            g3_reg   <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (pos_reg < 17'd4)
                begin
                    seq_reg <= {seq_reg[23:0], data_byte};
                end
                else if (pos_reg < 17'd8)
                begin
                    ts_reg <= {ts_reg[23:0], data_byte};
                end
                else if (pos_reg < 17'd10)
                begin
                    size_reg <= {size_reg[7:0], data_byte};
                end
                else if (pos_reg < tpc_pkg::HDR_LEN)
                begin
                    chk_reg <= chk_new;
                end
                if (pos_reg == tpc_pkg::HDR_LEN - 17'd1)
                begin
                    bad_reg <= (sum16 != chk_new);
                    g0_reg  <= tpc_pkg::SEED_A ^ seed;
                    g1_reg  <= tpc_pkg::SEED_B + seed;
                    g2_reg  <= tpc_pkg::SEED_C - seed;
                    g3_reg  <= tpc_pkg::SEED_D ^ seed;
                end
                else if (pos_reg >= tpc_pkg::HDR_LEN)
                begin
                    g0_reg <= a1;
                    g1_reg <= b1;
                    g2_reg <= c1;
                end
                if (pos_reg != tpc_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 17'd1;
                end
            end
            if (cmd.gen)
            begin
                g0_reg <= a3;
                g1_reg <= b3;
                g2_reg <= c3;
                g3_reg <= d3;
                if (a3[7:0] != byte_reg && mcnt_reg != 16'hffff)
                begin
                    mcnt_reg <= mcnt_reg + 16'd1;
                end
            end
            if (cmd.fin)
            begin
                if (!st.short_pkt && !bad_reg)
                begin
                    prev_reg <= seq_reg;
                end
                seen_reg <= 1'b1;
                pos_reg  <= '0;
                mcnt_reg <= '0;
                bad_reg  <= 1'b0;
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.restart)
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan1 || cmd.scan2)
            begin
                if (cnt_reg != fill_reg)
                begin
                    cnt_reg  <= cnt_reg + FW'(1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.swap_js)
            begin
                head_reg <= wrap(head_reg, FW'(1));
                fill_reg <= fill_reg - FW'(1);
            end
            if (cmd.insert)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_reg  <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fin)
            begin
                dup_reg  <= 1'b0;
                have_reg <= 1'b0;
            end
            if (cmd.scan1 && pend_reg)
            begin
                if ((off_reg == '0 && st.full && seq_reg < v) || v == seq_reg)
                begin
                    dup_reg <= 1'b1;
                end
            end
            if (cmd.scan2 && pend_reg && v > s0_reg && (!have_reg || v < s1_reg))
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.scan1 || cmd.scan2)
        begin
            off_reg  <= cnt_reg[IW-1:0];
            phys_reg <= rd_addr;
        end
        if (cmd.scan1 && pend_reg)
        begin
            if (off_reg == '0)
            begin
                h0_reg <= v;
            end
            if (off_reg == '0 || v < s0_reg)
            begin
                s0_reg <= v;
                js_reg <= phys_reg;
            end
        end
        if (cmd.scan2 && pend_reg && v > s0_reg && (!have_reg || v < s1_reg))
        begin
            s1_reg <= v;
        end
        if (cmd.fin)
        begin
            r_outcome_reg <= tpc_pkg::OUTCOME_OK;
            r_ooo_reg     <= 1'b0;
            r_trunc_reg   <= 1'b0;
            r_pbad_reg    <= 1'b0;
            r_seq_reg     <= '0;
            r_err_reg     <= '0;
            r_gap_reg     <= 1'b0;
            r_first_reg   <= '0;
            r_last_reg    <= '0;
            if (st.short_pkt)
            begin
                r_outcome_reg <= tpc_pkg::OUTCOME_SHORT;
            end
            else if (bad_reg)
            begin
                r_outcome_reg <= tpc_pkg::OUTCOME_BAD;
            end
            else
            begin
                r_seq_reg <= seq_reg;
                r_ooo_reg <= seen_reg && (seq_reg < prev_reg);
                if (plen != {1'b0, size_reg})
                begin
                    r_trunc_reg <= 1'b1;
                end
                else
                begin
                    r_err_reg  <= mcnt_reg;
                    r_pbad_reg <= (mcnt_reg != '0);
                end
            end
        end
        if (cmd.swap_head && have_reg && s1_reg != s0_reg + 32'd1)
        begin
            r_gap_reg   <= 1'b1;
            r_first_reg <= s0_reg + 32'd1;
            r_last_reg  <= s1_reg - 32'd1;
        end
    end

    assign outcome      = r_outcome_reg;
    assign misordered   = r_ooo_reg;
    assign duplicate    = dup_reg;
    assign truncated    = r_trunc_reg;
    assign payload_bad  = r_pbad_reg;
    assign sequence_res = r_seq_reg;
    assign byte_errors  = r_err_reg;
    assign gap_found    = r_gap_reg;
    assign gap_first    = r_first_reg;
    assign gap_last     = r_last_reg;

endmodule

@@ rtl/core/test_packet_checker_unit.sv @@
// Test packet checker: takes one packet byte per transaction (header first, last_byte on
// the final byte) and returns one result transaction per packet. Each payload byte also
// passes a generate state, as the byte predictor's rotate/add chain is split between the
// take and generate steps. After the last byte, a finish state settles the header checks;
// a valid header then walks the reorder window RAM one entry per cycle: a duplicate and
// smallest-entry pass, then a next-larger pass when the window is full, then the swap and
// insert writes on its single write port. The result stays registered until taken, and
// no new byte is taken meanwhile.
module test_packet_checker_unit #(
    parameter int WINDOW_DEPTH = tpc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  outcome,
    output logic        misordered,
    output logic        duplicate,
    output logic        truncated,
    output logic        payload_bad,
    output logic [31:0] sequence_res,
    output logic [15:0] byte_errors,
    output logic        gap_found,
    output logic [31:0] gap_first,
    output logic [31:0] gap_last
);

    tpc_pkg::cmd_t    cmd;
    tpc_pkg::status_t st;

    tpc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .st           (st),
        .cmd          (cmd)
    );

    tpc_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .st           (st),
        .outcome      (outcome),
        .misordered   (misordered),
        .duplicate    (duplicate),
        .truncated    (truncated),
        .payload_bad  (payload_bad),
        .sequence_res (sequence_res),
        .byte_errors  (byte_errors),
        .gap_found    (gap_found),
        .gap_first    (gap_first),
        .gap_last     (gap_last)
    );

endmodule

@@ rtl/core/tpc_checker.sv @@
module tpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        data_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  outcome,
    input logic [31:0] sequence_res,
    input logic        gap_found,
    input logic [31:0] gap_first,
    input logic [31:0] gap_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(sequence_res))
        else $error("result dropped or changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(data_ready && result_valid))
        else $error("byte taken while result pending");

    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outcome == tpc_pkg::OUTCOME_OK || outcome == tpc_pkg::OUTCOME_SHORT
                         || outcome == tpc_pkg::OUTCOME_BAD)
        else $error("bad outcome code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outcome != tpc_pkg::OUTCOME_OK |-> sequence_res == '0 && !gap_found)
        else $error("fields set for rejected packet");

    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !gap_found |-> gap_first == '0 && gap_last == '0)
        else $error("gap bounds without gap");

endmodule

bind test_packet_checker_unit tpc_checker u_tpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_ready   (data_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .outcome      (outcome),
    .sequence_res (sequence_res),
    .gap_found    (gap_found),
    .gap_first    (gap_first),
    .gap_last     (gap_last)
);

@@ tb/tb.sv @@
module tb;

    localparam int WIN = 16;
    localparam int LIMIT = 2000000;
    localparam int SETTLE = 2 * WIN + 30;

    typedef struct {
        logic [1:0]  outcome;
        logic        misordered;
        logic        duplicate;
        logic        truncated;
        logic        payload_bad;
        logic [31:0] sequence_res;
        logic [15:0] byte_errors;
        logic        gap_found;
        logic [31:0] gap_first;
        logic [31:0] gap_last;
    } verdict_t;

    class packet_scoreboard;
        logic [16:0] pos;
        logic [31:0] hdr_seq, hdr_ts;
        logic [15:0] hdr_size, hdr_check;
        logic [31:0] gw[4];
        logic [15:0] mism;
        bit          sum_bad;
        logic [31:0] prev_seq;
        bit          seen_any;
        logic [31:0] win[WIN];
        int          head, fill;
        verdict_t    pending[$];
        int          errors;

        function new();
            pos = 0; hdr_seq = 0; hdr_ts = 0; hdr_size = 0; hdr_check = 0;
            foreach (gw[i]) gw[i] = 0;
            mism = 0; sum_bad = 0; prev_seq = 0; seen_any = 0;
            head = 0; fill = 0; errors = 0;
        endfunction

        static function logic [31:0] rot(logic [31:0] x, logic [31:0] y);
            int s;
            s = y[4:0];
            if (s == 0) return x;
            return (x << s) | (x >> (32 - s));
        endfunction

        static function void seed_words(inout logic [31:0] w[4], input logic [15:0] chk);
            logic [31:0] s;
            s = {16'h0, chk};
            w[0] = tpc_pkg::SEED_A ^ s;
            w[1] = tpc_pkg::SEED_B + s;
            w[2] = tpc_pkg::SEED_C - s;
            w[3] = tpc_pkg::SEED_D ^ s;
        endfunction

        static function logic [7:0] next_byte(inout logic [31:0] w[4]);
            logic [31:0] a, b, c, d;
            a = w[0]; b = w[1]; c = w[2]; d = w[3];
            a = rot(a, d);
            b ^= tpc_pkg::MIX_B;
            c = rot(c, b);
            d = rot(d, a);
            c ^= tpc_pkg::MIX_C;
            a ^= tpc_pkg::MIX_A;
            b = rot(b, c);
            a += c;
            b ^= d;
            c -= a;
            d -= b;
            d ^= tpc_pkg::MIX_D;
            w[0] = a; w[1] = b; w[2] = c; w[3] = d;
            return a[7:0];
        endfunction

        function void window_insert(logic [31:0] sq, ref verdict_t v);
            int js, j;
            logic [31:0] s0, s1, t;
            bit have;
            if (fill == WIN && sq < win[head])
            begin
                v.duplicate = 1;
                return;
            end
            for (int i = 0; i < fill; i++)
                if (win[(head + i) % WIN] == sq)
                begin
                    v.duplicate = 1;
                    return;
                end
            if (fill == WIN)
            begin
                js = head; s0 = win[head]; s1 = 0; have = 0;
                for (int i = 1; i < fill; i++)
                begin
                    j = (head + i) % WIN;
                    if (win[j] < s0)
                    begin
                        s0 = win[j];
                        js = j;
                    end
                end
                for (int i = 0; i < fill; i++)
                begin
                    t = win[(head + i) % WIN];
                    if (t > s0 && (!have || t < s1))
                    begin
                        s1 = t;
                        have = 1;
                    end
                end
                if (have && s1 - s0 - 1 != 0)
                begin
                    v.gap_found = 1;
                    v.gap_first = s0 + 1;
                    v.gap_last = s1 - 1;
                end
                t = win[head];
                win[head] = win[js];
                win[js] = t;
                head = (head + 1) % WIN;
                fill--;
            end
            win[(head + fill) % WIN] = sq;
            fill++;
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            logic [16:0] p;
            logic [15:0] sum;
            verdict_t v;
            p = pos;
            if (p < 4) hdr_seq = {hdr_seq[23:0], b};
            else if (p < 8) hdr_ts = {hdr_ts[23:0], b};
            else if (p < 10) hdr_size = {hdr_size[7:0], b};
            else if (p < tpc_pkg::HDR_LEN) hdr_check = {hdr_check[7:0], b};
            if (p == tpc_pkg::HDR_LEN - 1)
            begin
                sum = ~(hdr_seq[15:0] ^ hdr_ts[15:0] ^ hdr_size);
                sum_bad = (sum != hdr_check);
                seed_words(gw, hdr_check);
            end
            else if (p >= tpc_pkg::HDR_LEN)
            begin
                if (next_byte(gw) != b && mism != 16'hffff) mism++;
            end
            if (p < tpc_pkg::POS_MAX) pos = p + 1;
            if (!lst) return;
            v = '{default: 0};
            if (p + 1 < tpc_pkg::HDR_LEN) v.outcome = tpc_pkg::OUTCOME_SHORT;
            else if (sum_bad) v.outcome = tpc_pkg::OUTCOME_BAD;
            else
            begin
                v.outcome = tpc_pkg::OUTCOME_OK;
                v.sequence_res = hdr_seq;
                v.misordered = seen_any && hdr_seq < prev_seq;
                prev_seq = hdr_seq;
                window_insert(hdr_seq, v);
                if (p + 1 - tpc_pkg::HDR_LEN != {1'b0, hdr_size}) v.truncated = 1;
                else
                begin
                    v.byte_errors = mism;
                    v.payload_bad = mism != 0;
                end
            end
            seen_any = 1;
            pos = 0; mism = 0; sum_bad = 0;
            pending.push_back(v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t e;
            if (pending.size() == 0)
            begin
                $error("result with no packet outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.outcome !== e.outcome)
            begin
                $error("outcome exp %0d got %0d", e.outcome, got.outcome); errors++;
            end
            if (got.misordered !== e.misordered)
            begin
                $error("misordered exp %0d got %0d", e.misordered, got.misordered);
                errors++;
            end
            if (got.duplicate !== e.duplicate)
            begin
                $error("duplicate exp %0d got %0d", e.duplicate, got.duplicate); errors++;
            end
            if (got.truncated !== e.truncated)
            begin
                $error("truncated exp %0d got %0d", e.truncated, got.truncated); errors++;
            end
            if (got.payload_bad !== e.payload_bad)
            begin
                $error("payload_bad exp %0d got %0d", e.payload_bad, got.payload_bad);
                errors++;
            end
            if (got.sequence_res !== e.sequence_res)
            begin
                $error("sequence_res exp %h got %h", e.sequence_res, got.sequence_res);
                errors++;
            end
            if (got.byte_errors !== e.byte_errors)
            begin
                $error("byte_errors exp %0d got %0d", e.byte_errors, got.byte_errors);
                errors++;
            end
            if (got.gap_found !== e.gap_found)
            begin
                $error("gap_found exp %0d got %0d", e.gap_found, got.gap_found); errors++;
            end
            if (got.gap_first !== e.gap_first)
            begin
                $error("gap_first exp %h got %h", e.gap_first, got.gap_first);
                errors++;
            end
            if (got.gap_last !== e.gap_last)
            begin
                $error("gap_last exp %h got %h", e.gap_last, got.gap_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        data_valid;
    logic        data_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        result_valid;
    logic        result_ready;
    logic [1:0]  outcome;
    logic        misordered;
    logic        duplicate;
    logic        truncated;
    logic        payload_bad;
    logic [31:0] sequence_res;
    logic [15:0] byte_errors;
    logic        gap_found;
    logic [31:0] gap_first;
    logic [31:0] gap_last;

    packet_scoreboard sb = new();
    int  cycles = 0;
    int  bytes_sent = 0;
    int  results_taken = 0;
    bit  send_idle = 1;
    bit  held = 0;
    logic [31:0] next_seq = 32'd100;

    test_packet_checker_unit dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        verdict_t r;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        if (rst_n && data_valid && data_ready)
            sb.note_byte(data_byte, last_byte);
        if (rst_n && result_valid && result_ready)
        begin
            r.outcome = outcome;
            r.misordered = misordered;
            r.duplicate = duplicate;
            r.truncated = truncated;
            r.payload_bad = payload_bad;
            r.sequence_res = sequence_res;
            r.byte_errors = byte_errors;
            r.gap_found = gap_found;
            r.gap_first = gap_first;
            r.gap_last = gap_last;
            sb.check_result(r);
            results_taken++;
        end
    end

    // result side: random stalls, one long hold-off to back up the input
    initial
    begin
        int n;
        result_ready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            n = $urandom_range(7);
            if (results_taken >= 20 && !held)
            begin
                held = 1;
                n = 400;
            end
            else if (results_taken % 50 > 35)
                n = 0;
            if (n > 0)
            begin
                result_ready <= 0;
                repeat (n) @(posedge clk);
            end
            result_ready <= 1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic lst);
        int g;
        g = send_idle ? $urandom_range(7) : 0;
        if (g > 0)
        begin
            data_valid <= 0;
            repeat (g) @(posedge clk);
        end
        data_valid <= 1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (!data_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_raw(int len);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(255), i == len - 1);
    endtask

    task automatic send_packet(logic [31:0] sq, logic [31:0] ts, logic [15:0] sz,
                               int plen, bit corrupt, int err_pct);
        logic [15:0] chk;
        logic [31:0] w[4];
        logic [7:0] hdr[12];
        logic [7:0] b;
        chk = ~(sq[15:0] ^ ts[15:0] ^ sz);
        if (corrupt) chk ^= 16'($urandom_range(65535, 1));
        hdr = '{sq[31:24], sq[23:16], sq[15:8], sq[7:0], ts[31:24], ts[23:16], ts[15:8],
                ts[7:0], sz[15:8], sz[7:0], chk[15:8], chk[7:0]};
        for (int i = 0; i < 12; i++) send_byte(hdr[i], plen == 0 && i == 11);
        packet_scoreboard::seed_words(w, chk);
        for (int i = 0; i < plen; i++)
        begin
            b = packet_scoreboard::next_byte(w);
            if ($urandom_range(99) < err_pct) b ^= 8'($urandom_range(255, 1));
            send_byte(b, i == plen - 1);
        end
    endtask

    task automatic drain();
        data_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_packet();
        int k, sz, plen;
        logic [31:0] sq;
        k = $urandom_range(99);
        if (k < 5) send_raw($urandom_range(11, 1));
        else if (k < 10) send_raw($urandom_range(30, 12));
        else
        begin
            sz = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
            plen = ($urandom_range(9) == 0) ? $urandom_range(sz + 3) : sz;
            k = $urandom_range(99);
            if (k < 60) sq = next_seq + 1;
            else if (k < 75) sq = next_seq + $urandom_range(6, 2);
            else if (k < 85) sq = next_seq - $urandom_range(20);
            else if (k < 90) sq = next_seq;
            else sq = next_seq + $urandom_range(40);
            if (sq > next_seq) next_seq = sq;
            send_packet(sq, $urandom, sz, plen, $urandom_range(9) == 0,
                        $urandom_range(1) ? 0 : $urandom_range(30));
        end
    endtask

    initial
    begin
        rst_n = 0;
        data_valid = 0;
        data_byte = 0;
        last_byte = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_raw(1);
        send_raw(11);
        send_packet(32'h0, 32'h0, 16'd0, 0, 1, 0);
        send_packet(32'h0, 32'hffffffff, 16'd0, 0, 0, 0);
        send_packet(32'h0, 32'h12345678, 16'd3, 3, 0, 0);
        send_packet(32'hffffffff, 32'h0, 16'hffff, 4, 0, 0);
        send_packet(32'd7, 32'hffffffff, 16'd8, 8, 0, 100);
        send_packet(32'd5, 32'hffffffff, 16'd4, 3, 0, 0);
        send_packet(32'd6, 32'h0, 16'd2, 6, 0, 50);
        for (int i = 0; i < 14; i++)
            send_packet(32'd10 + 3 * i, $urandom, 16'd1, 1, 0, 0);
        drain();

        // longer packets without sender gaps
        send_idle = 0;
        send_packet(32'd200, 32'h0, 16'd300, 300, 0, 100);
        send_packet(32'd201, 32'h0, 16'd300, 340, 0, 0);
        send_idle = 1;
        next_seq = 32'd201;

        while (bytes_sent < 2000)
        begin
            if ($urandom_range(15) == 0) send_idle = !send_idle;
            random_packet();
        end
        send_idle = 1;
        @(posedge clk);
        data_valid <= 0;
        drain();

        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
